@@ src/tcps_pkg.sv @@
// Package for the two-class priority server: shared widths, default parameter
// values, start codes and the saturating accumulate helper.
// No dependencies.
package tcps_pkg;

    localparam int QUEUE_DEPTH_DEF  = 16;
    localparam int SERVICE_BITS_DEF = 8;
    localparam int SUM_BITS         = 48;
    localparam int TICK_BITS        = 32;
    localparam int OUT_BITS         = 232;

    localparam logic [1:0] START_NONE = 2'd0;
    localparam logic [1:0] START_HI   = 2'd1;
    localparam logic [1:0] START_LO   = 2'd2;

    function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] acc,
                                                    input logic [SUM_BITS-1:0] v);
        logic [SUM_BITS:0] s;
        s = {1'b0, acc} + {1'b0, v};
        return s[SUM_BITS] ? {SUM_BITS{1'b1}} : s[SUM_BITS-1:0];
    endfunction

endpackage

@@ src/two_class_priority_server_top.sv @@
// A result is registered in the accept stage (a_*) and then in the output stage (m_*).
// Throughput: one item per cycle while m_tready does not stall the output; control
// state is updated in the accept cycle; FIFO head entries are prefetched from memory.
// Reset (aresetn low, synchronous) clears pointers, counts, server state, tick
// and totals; the two task memories are not cleared.
// Depends on tcps_pkg.
module two_class_priority_server_top
    import tcps_pkg::*;
#(
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
    parameter int SERVICE_BITS = SERVICE_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // arrive_hi, service_hi, arrive_lo, service_lo, zero padding
    input  logic [((2*SERVICE_BITS+2+7)/8)*8-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // started, finished, server_busy, dropped_hi, dropped_lo, wait_total_hi,
    // wait_total_lo, queue_len_total, service_total, tick_now, zero padding
    output logic [OUT_BITS-1:0]  m_tdata
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SB = SERVICE_BITS;
    localparam int EW = TICK_BITS + SB;
    localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    logic [EW-1:0] mem_hi [QUEUE_DEPTH];
    logic [EW-1:0] mem_lo [QUEUE_DEPTH];

    logic [IW-1:0] head_hi_reg, head_hi_next, tail_hi_reg, tail_hi_next;
    logic [IW-1:0] head_lo_reg, head_lo_next, tail_lo_reg, tail_lo_next;
    logic [CW-1:0] cnt_hi_reg, cnt_hi_next, cnt_lo_reg, cnt_lo_next;
    logic [SB-1:0] rem_reg, rem_next;
    logic          busy_reg, busy_next;
    logic [TICK_BITS-1:0] tick_reg, tick_next;

    logic [EW-1:0] rd_hi_reg, rd_lo_reg, byp_hi_data_reg, byp_lo_data_reg;
    logic          byp_hi_reg, byp_lo_reg;

    logic          a_valid_reg;
    logic [1:0]    a_started_reg;
    logic          a_finished_reg, a_busy_reg, a_drop_hi_reg, a_drop_lo_reg;
    logic [TICK_BITS-1:0] a_tick_reg, a_wait_reg;
    logic [SB-1:0] a_serv_reg;
    logic [CW:0]   a_qadd_reg;

    logic          m_valid_reg;
    logic [1:0]    m_started_reg;
    logic          m_finished_reg, m_busy_reg, m_drop_hi_reg, m_drop_lo_reg;
    logic [TICK_BITS-1:0] m_tick_reg;
    logic [SUM_BITS-1:0]  sum_wait_hi_reg, sum_wait_lo_reg, sum_qlen_reg, sum_serv_reg;

    logic          accept, enable_b;
    logic          arrive_hi, arrive_lo;
    logic [SB-1:0] service_hi, service_lo, serv_hi_clean, serv_lo_clean;
    logic          wr_hi, wr_lo, drop_hi, drop_lo, start_hi, start_lo, started_any;
    logic [CW-1:0] cnt_hi_push, cnt_lo_push;
    logic [EW-1:0] entry_hi, entry_lo, entry_sel, wdata_hi, wdata_lo;
    logic [SB-1:0] rem_cur, rem_dec;
    logic          busy_cur, finished;
    logic [1:0]    started;
    logic [TICK_BITS-1:0] wait_val;
    logic [CW:0]   qadd;

    assign enable_b = !m_valid_reg || m_tready;
    assign s_tready = !a_valid_reg || enable_b;
    assign accept   = s_tvalid && s_tready;

    assign arrive_hi  = s_tdata[0];
    assign service_hi = s_tdata[SB:1];
    assign arrive_lo  = s_tdata[SB+1];
    assign service_lo = s_tdata[2*SB+1:SB+2];

    assign serv_hi_clean = (service_hi == '0) ? SB'(1) : service_hi;
    assign serv_lo_clean = (service_lo == '0) ? SB'(1) : service_lo;
    assign wdata_hi = {tick_reg, serv_hi_clean};
    assign wdata_lo = {tick_reg, serv_lo_clean};

    always_comb begin
        drop_hi     = accept && arrive_hi && (cnt_hi_reg >= FULL_CNT);
        wr_hi       = accept && arrive_hi && (cnt_hi_reg < FULL_CNT);
        drop_lo     = accept && arrive_lo && (cnt_lo_reg >= FULL_CNT);
        wr_lo       = accept && arrive_lo && (cnt_lo_reg < FULL_CNT);
        cnt_hi_push = cnt_hi_reg + CW'(wr_hi);
        cnt_lo_push = cnt_lo_reg + CW'(wr_lo);

        entry_hi = (cnt_hi_reg == '0) ? wdata_hi : (byp_hi_reg ? byp_hi_data_reg : rd_hi_reg);
        entry_lo = (cnt_lo_reg == '0) ? wdata_lo : (byp_lo_reg ? byp_lo_data_reg : rd_lo_reg);

        start_hi    = accept && !busy_reg && (cnt_hi_push != '0);
        start_lo    = accept && !busy_reg && (cnt_hi_push == '0) && (cnt_lo_push != '0);
        started_any = start_hi || start_lo;
        started     = start_hi ? START_HI : (start_lo ? START_LO : START_NONE);
        entry_sel   = start_hi ? entry_hi : entry_lo;
        wait_val    = tick_reg - entry_sel[EW-1:SB];

        cnt_hi_next = cnt_hi_push - CW'(start_hi);
        cnt_lo_next = cnt_lo_push - CW'(start_lo);
        head_hi_next = head_hi_reg;
        head_lo_next = head_lo_reg;
        tail_hi_next = tail_hi_reg;
        tail_lo_next = tail_lo_reg;
        if (start_hi) begin
            head_hi_next = (head_hi_reg == LAST_IDX) ? '0 : head_hi_reg + IW'(1);
        end
        if (start_lo) begin
            head_lo_next = (head_lo_reg == LAST_IDX) ? '0 : head_lo_reg + IW'(1);
        end
        if (wr_hi) begin
            tail_hi_next = (tail_hi_reg == LAST_IDX) ? '0 : tail_hi_reg + IW'(1);
        end
        if (wr_lo) begin
            tail_lo_next = (tail_lo_reg == LAST_IDX) ? '0 : tail_lo_reg + IW'(1);
        end

        qadd = (wr_hi ? {1'b0, cnt_hi_push} : '0) + (wr_lo ? {1'b0, cnt_lo_push} : '0);

        rem_cur   = started_any ? entry_sel[SB-1:0] : rem_reg;
        busy_cur  = busy_reg || started_any;
        rem_dec   = rem_cur - SB'(1);
        finished  = accept && busy_cur && (rem_dec == '0);
        busy_next = busy_reg;
        rem_next  = rem_reg;
        tick_next = tick_reg;
        if (accept) begin
            busy_next = busy_cur && !finished;
            rem_next  = busy_cur ? rem_dec : rem_reg;
            tick_next = tick_reg + TICK_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_hi) begin
            mem_hi[tail_hi_reg] <= wdata_hi;
        end
        if (wr_lo) begin
            mem_lo[tail_lo_reg] <= wdata_lo;
        end
        rd_hi_reg       <= mem_hi[head_hi_next];
        rd_lo_reg       <= mem_lo[head_lo_next];
        byp_hi_data_reg <= wdata_hi;
        byp_lo_data_reg <= wdata_lo;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_hi_reg <= '0;
            tail_hi_reg <= '0;
            cnt_hi_reg  <= '0;
            head_lo_reg <= '0;
            tail_lo_reg <= '0;
            cnt_lo_reg  <= '0;
            rem_reg     <= '0;
            busy_reg    <= 1'b0;
            tick_reg    <= '0;
            byp_hi_reg  <= 1'b0;
            byp_lo_reg  <= 1'b0;
            a_valid_reg <= 1'b0;
        end else begin
            head_hi_reg <= head_hi_next;
            tail_hi_reg <= tail_hi_next;
            cnt_hi_reg  <= cnt_hi_next;
            head_lo_reg <= head_lo_next;
            tail_lo_reg <= tail_lo_next;
            cnt_lo_reg  <= cnt_lo_next;
            rem_reg     <= rem_next;
            busy_reg    <= busy_next;
            tick_reg    <= tick_next;
            byp_hi_reg  <= wr_hi && (tail_hi_reg == head_hi_next);
            byp_lo_reg  <= wr_lo && (tail_lo_reg == head_lo_next);
            if (s_tready) begin
                a_valid_reg <= accept;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_started_reg  <= started;
            a_finished_reg <= finished;
            a_busy_reg     <= busy_next;
            a_drop_hi_reg  <= drop_hi;
            a_drop_lo_reg  <= drop_lo;
            a_tick_reg     <= tick_next;
            a_wait_reg     <= wait_val;
            a_serv_reg     <= entry_sel[SB-1:0];
            a_qadd_reg     <= qadd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg     <= 1'b0;
            sum_wait_hi_reg <= '0;
            sum_wait_lo_reg <= '0;
            sum_qlen_reg    <= '0;
            sum_serv_reg    <= '0;
        end else if (enable_b) begin
            m_valid_reg <= a_valid_reg;
            if (a_valid_reg) begin
                if (a_started_reg == START_HI) begin
                    sum_wait_hi_reg <= sat_add(sum_wait_hi_reg, SUM_BITS'(a_wait_reg));
                end
                if (a_started_reg == START_LO) begin
                    sum_wait_lo_reg <= sat_add(sum_wait_lo_reg, SUM_BITS'(a_wait_reg));
                end
                if (a_started_reg != START_NONE) begin
                    sum_serv_reg <= sat_add(sum_serv_reg, SUM_BITS'(a_serv_reg));
                end
                sum_qlen_reg <= sat_add(sum_qlen_reg, SUM_BITS'(a_qadd_reg));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (enable_b && a_valid_reg) begin
            m_started_reg  <= a_started_reg;
            m_finished_reg <= a_finished_reg;
            m_busy_reg     <= a_busy_reg;
            m_drop_hi_reg  <= a_drop_hi_reg;
            m_drop_lo_reg  <= a_drop_lo_reg;
            m_tick_reg     <= a_tick_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_tick_reg, sum_serv_reg, sum_qlen_reg, sum_wait_lo_reg,
                       sum_wait_hi_reg, m_drop_lo_reg, m_drop_hi_reg, m_busy_reg,
                       m_finished_reg, m_started_reg};

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for two_class_priority_server_top: random tick streams with
// idle gaps and back-pressure, checked against a per-tick predictor of the server.
// Depends on tcps_pkg and the RTL top level only.
module testbench
    import tcps_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SB   = SERVICE_BITS_DEF;
    localparam int IN_W = ((2*SB+2+7)/8)*8;

    class tcps_scoreboard;
        typedef struct {
            logic [1:0]          started;
            logic                finished;
            logic                busy;
            logic                drop_hi;
            logic                drop_lo;
            logic [SUM_BITS-1:0] wait_hi;
            logic [SUM_BITS-1:0] wait_lo;
            logic [SUM_BITS-1:0] qlen;
            logic [SUM_BITS-1:0] serv;
            logic [TICK_BITS-1:0] tick;
        } tick_result_t;

        bit [TICK_BITS-1:0]  stamp_q[2][QUEUE_DEPTH_DEF];
        bit [SB-1:0]         serv_q[2][QUEUE_DEPTH_DEF];
        int                  head[2];
        int                  tail[2];
        int                  fill[2];
        bit [SB-1:0]         remaining;
        bit                  busy;
        bit [TICK_BITS-1:0]  tick;
        bit [SUM_BITS-1:0]   wait_sum[2];
        bit [SUM_BITS-1:0]   qlen_sum;
        bit [SUM_BITS-1:0]   serv_sum;
        tick_result_t        due[$];
        int                  errors;
        int                  items;
        int                  results;
        int                  starts[2];
        int                  drops[2];
        int                  finishes;

        function new();
            head = '{0, 0};
            tail = '{0, 0};
            fill = '{0, 0};
            wait_sum = '{0, 0};
            starts = '{0, 0};
            drops = '{0, 0};
        endfunction

        function bit [SUM_BITS-1:0] sum_sat(bit [SUM_BITS-1:0] acc, bit [SUM_BITS-1:0] v);
            bit [SUM_BITS-1:0] top;
            top = {SUM_BITS{1'b1}};
            return (acc > top - v) ? top : acc + v;
        endfunction

        function bit push_task(int c, bit [SB-1:0] raw);
            if (fill[c] == QUEUE_DEPTH_DEF) begin
                drops[c]++;
                return 1'b1;
            end
            stamp_q[c][tail[c]] = tick;
            serv_q[c][tail[c]] = (raw == '0) ? SB'(1) : raw;
            tail[c] = (tail[c] + 1) % QUEUE_DEPTH_DEF;
            fill[c]++;
            qlen_sum = sum_sat(qlen_sum, SUM_BITS'(fill[c]));
            return 1'b0;
        endfunction

        function void start_task(int c);
            bit [TICK_BITS-1:0] waited;
            waited = tick - stamp_q[c][head[c]];
            wait_sum[c] = sum_sat(wait_sum[c], SUM_BITS'(waited));
            remaining = serv_q[c][head[c]];
            serv_sum = sum_sat(serv_sum, SUM_BITS'(remaining));
            busy = 1'b1;
            head[c] = (head[c] + 1) % QUEUE_DEPTH_DEF;
            fill[c]--;
            starts[c]++;
        endfunction

        function void note(bit ah, bit [SB-1:0] sh, bit al, bit [SB-1:0] sl);
            tick_result_t r;
            r.started = START_NONE;
            r.finished = 1'b0;
            r.drop_hi = ah ? push_task(0, sh) : 1'b0;
            if (!busy && fill[0] > 0) begin
                start_task(0);
                r.started = START_HI;
            end
            r.drop_lo = al ? push_task(1, sl) : 1'b0;
            if (!busy && fill[0] == 0 && fill[1] > 0) begin
                start_task(1);
                r.started = START_LO;
            end
            tick = tick + TICK_BITS'(1);
            if (busy) begin
                remaining = remaining - SB'(1);
                if (remaining == '0) begin
                    r.finished = 1'b1;
                    busy = 1'b0;
                    finishes++;
                end
            end
            r.busy = busy;
            r.wait_hi = wait_sum[0];
            r.wait_lo = wait_sum[1];
            r.qlen = qlen_sum;
            r.serv = serv_sum;
            r.tick = tick;
            due.push_back(r);
            items++;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 20) begin
                $display("ERROR [%0t] result %0d: %s", $realtime, results, msg);
            end
        endtask

        task compare_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want) begin
                report($sformatf("%s got %0h expected %0h", name, got, want));
            end
        endtask

        task check(logic [OUT_BITS-1:0] v);
            tick_result_t r;
            if (due.size() == 0) begin
                report("result transfer with nothing expected");
                return;
            end
            r = due.pop_front();
            compare_field("started", 64'(v[1:0]), 64'(r.started));
            compare_field("finished", 64'(v[2]), 64'(r.finished));
            compare_field("server_busy", 64'(v[3]), 64'(r.busy));
            compare_field("dropped_hi", 64'(v[4]), 64'(r.drop_hi));
            compare_field("dropped_lo", 64'(v[5]), 64'(r.drop_lo));
            compare_field("wait_total_hi", 64'(v[53:6]), 64'(r.wait_hi));
            compare_field("wait_total_lo", 64'(v[101:54]), 64'(r.wait_lo));
            compare_field("queue_len_total", 64'(v[149:102]), 64'(r.qlen));
            compare_field("service_total", 64'(v[197:150]), 64'(r.serv));
            compare_field("tick_now", 64'(v[229:198]), 64'(r.tick));
            compare_field("padding", 64'(v[OUT_BITS-1:230]), '0);
            results++;
        endtask

        function int pending();
            return due.size();
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_BITS-1:0] m_tdata;

    tcps_scoreboard sb = new();
    bit             send_gaps;
    int             input_stalls;

    two_class_priority_server_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note(s_tdata[0], s_tdata[SB:1], s_tdata[SB+1], s_tdata[2*SB+1:SB+2]);
            end
            if (s_tvalid && !s_tready) begin
                input_stalls++;
            end
            if (m_tvalid && m_tready) begin
                sb.check(m_tdata);
            end
        end
    end

    function automatic logic [IN_W-1:0] pack_tick(bit ah, bit [SB-1:0] sh, bit al,
                                                  bit [SB-1:0] sl);
        logic [IN_W-1:0] d;
        d = '0;
        d[0] = ah;
        d[SB:1] = sh;
        d[SB+1] = al;
        d[2*SB+1:SB+2] = sl;
        return d;
    endfunction

    function automatic bit [SB-1:0] draw_service();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 14) begin
            return SB'($urandom_range(0, 6));
        end else if (pick < 17) begin
            return SB'($urandom_range(0, 255));
        end else if (pick == 17) begin
            return SB'(0);
        end else if (pick == 18) begin
            return SB'(1);
        end
        return SB'(255);
    endfunction

    task automatic send_tick(input logic [IN_W-1:0] d);
        int gap;
        gap = send_gaps ? $urandom_range(0, 8) : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tdata <= IN_W'($urandom);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    initial begin : receiver
        int taken;
        int hold;
        bit stalls;
        taken = 0;
        stalls = 1'b0;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (taken % 40 == 0) begin
                stalls = ($urandom_range(0, 2) != 0);
            end
            hold = stalls ? $urandom_range(0, 8) : 0;
            if (taken == 400) begin
                hold = 300;
            end
            repeat (hold) begin
                @(negedge aclk);
                m_tready <= 1'b0;
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            taken++;
        end
    end

    initial begin : watchdog
        #2000000;
        $display("Timeout with %0d results still expected.", sb.pending());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        int pct_hi;
        int pct_lo;
        int pct_set[4];
        pct_set = '{5, 20, 50, 90};
        input_stalls = 0;
        send_gaps = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        // Idle tick, one-tick tasks of both classes, zero service, then a long
        // high task that lets both queues fill up until arrivals are dropped.
        send_tick(pack_tick(1'b0, SB'(0), 1'b0, SB'(0)));
        send_tick(pack_tick(1'b1, SB'(1), 1'b0, SB'(0)));
        send_tick(pack_tick(1'b0, SB'(0), 1'b1, SB'(0)));
        send_tick(pack_tick(1'b1, SB'(0), 1'b1, SB'(1)));
        send_tick(pack_tick(1'b1, SB'(255), 1'b1, SB'(255)));
        for (int i = 0; i < 17; i++) begin
            send_gaps = (i >= 8);
            send_tick(pack_tick(1'b1,
                                (i % 4 == 0) ? SB'(0) : SB'($urandom_range(0, 255)),
                                1'b1,
                                (i % 4 == 1) ? SB'(255) : SB'($urandom_range(0, 255))));
        end

        pct_hi = 50;
        pct_lo = 50;
        for (int n = 0; n < 1580; n++) begin
            if (n % 50 == 0) begin
                pct_hi = pct_set[$urandom_range(0, 3)];
                pct_lo = pct_set[$urandom_range(0, 3)];
                send_gaps = ($urandom_range(0, 3) != 0);
            end
            send_tick(pack_tick($urandom_range(1, 100) <= pct_hi, draw_service(),
                                $urandom_range(1, 100) <= pct_lo, draw_service()));
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        while (sb.pending() > 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Covered %0d ticks: %0d high and %0d low starts, %0d completions.",
                 sb.items, sb.starts[0], sb.starts[1], sb.finishes);
        $display("Full-queue drops: %0d high, %0d low; input held off for %0d cycles.",
                 sb.drops[0], sb.drops[1], input_stalls);
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches found.", sb.errors);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
